### hdl/uhs_pkg.sv
// Shared types, constants and character functions for the hostname slugger.
package uhs_pkg;

  // Default cap on the number of slug characters.
  localparam int MAX_LEN_DEFAULT = 63;

  // Depth of the command queue between scanner and emitter (power of two).
  localparam int QUEUE_DEPTH = 2;

  // Fallback text length and the width of an index into it.
  localparam int FALLBACK_LEN = 10;
  localparam int FB_IDX_W     = 4;

  // Character and byte constants.
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_NONE      = 8'h00;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [2:0] LEAD2_PREFIX = 3'b110;
  localparam logic [1:0] CONT_PREFIX  = 2'b10;

  // Work items handed from the scanner to the emitter.
  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_DASH_CHAR,
    CMD_END_FALLBACK,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
  } cmd_t;

  // Fold a Latin-1 code point (0xC0..0xFF, low 8 bits given) to a bare letter.
  // Returns CH_NONE when the code point is not a foldable letter.
  function automatic logic [7:0] fold_latin(input logic [7:0] cp);
    logic [7:0] x;
    x = cp | CASE_BIT;
    if (x >= 8'hE0 && x <= 8'hE5) return 8'h61;
    if (x == 8'hE7) return 8'h63;
    if (x >= 8'hE8 && x <= 8'hEB) return 8'h65;
    if (x >= 8'hEC && x <= 8'hEF) return 8'h69;
    if (x == 8'hF1) return 8'h6E;
    if (x >= 8'hF2 && x <= 8'hF6) return 8'h6F;
    if (x >= 8'hF9 && x <= 8'hFC) return 8'h75;
    return CH_NONE;
  endfunction

  // Classify a plain ASCII byte: lowercase letter or digit, else CH_NONE.
  function automatic logic [7:0] fold_ascii(input logic [7:0] b);
    if (b >= CH_LOWER_A && b <= CH_LOWER_Z) return b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) return b | CASE_BIT;
    if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) return b;
    return CH_NONE;
  endfunction

  // Characters of the fallback name used when the slug comes out empty.
  function automatic logic [7:0] fallback_char(input logic [FB_IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h68;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h2D;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h72;
      4'd6:    c = 8'h70;
      4'd7:    c = 8'h6C;
      4'd8:    c = 8'h61;
      4'd9:    c = 8'h79;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

### hdl/uhs_if.sv
// Valid/ready channel interfaces for name bytes and slug characters.
interface uhs_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;

  modport source (output valid, output name_byte, input ready);
  modport sink (input valid, input name_byte, output ready);
endinterface

interface uhs_slug_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_slug;

  modport source (output valid, output out_char, output end_of_slug, input ready);
  modport sink (input valid, input out_char, input end_of_slug, output ready);
endinterface

### hdl/utf8_hostname_slugger_unit.sv
// Top level of the UTF-8 name to hostname slug converter.
// A slug character reaches the output through the command queue and then the output register.
// Throughput: one name byte per cycle while the command queue is not full; a byte that
// releases a dash and a letter emits both, and the zero byte may emit the fallback name first.
// The command queue absorbs those bursts; the output register decouples the sink.
// Reset (rst, synchronous): flags to their idle values, queue empty, output invalid.
module utf8_hostname_slugger_unit #(
  parameter int MAX_LEN = uhs_pkg::MAX_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  uhs_name_if.sink   name_ch,
  uhs_slug_if.source slug_ch
);

  logic          queue_full;
  logic          push;
  uhs_pkg::cmd_t push_cmd;
  logic          head_valid;
  uhs_pkg::cmd_t head;
  logic          pop;

  // Byte decoding and slug state.
  uhs_scanner #(.MAX_LEN(MAX_LEN)) u_scanner (
    .clk        (clk),
    .rst        (rst),
    .name_ch    (name_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Command queue between front and back.
  uhs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Character emission.
  uhs_emitter #(.MAX_LEN(MAX_LEN)) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .slug_ch    (slug_ch)
  );

endmodule

### hdl/uhs_queue.sv
// Small command queue between the byte scanner and the character emitter.
module uhs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uhs_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output uhs_pkg::cmd_t head,
  input  logic          pop
);

  localparam int PTR_W = (uhs_pkg::QUEUE_DEPTH > 1) ? $clog2(uhs_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(uhs_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(uhs_pkg::QUEUE_DEPTH);

  uhs_pkg::cmd_t          entries [uhs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/uhs_scanner.sv
// Front end: accepts name bytes, decodes UTF-8 and tracks slug state.
module uhs_scanner #(
  parameter int MAX_LEN = uhs_pkg::MAX_LEN_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  uhs_name_if.sink      name_ch,
  input  logic          queue_full,
  output logic          push,
  output uhs_pkg::cmd_t push_cmd
);

  localparam int WCW = $clog2(MAX_LEN + 1);
  localparam logic [WCW-1:0] MAX_W = WCW'(MAX_LEN);

  logic [WCW-1:0] written_count, written_count_next;
  logic           last_was_separator, last_was_separator_next;
  logic           dash_pending, dash_pending_next;
  logic [4:0]     lead_bits, lead_bits_next;
  logic           lead_valid, lead_valid_next;
  logic           skipping_continuation, skipping_continuation_next;
  logic           length_capped, length_capped_next;

  logic           accept;
  logic [7:0]     b;
  logic           take_en;
  logic [7:0]     take_ch;
  logic [WCW-1:0] sent_count;

  assign name_ch.ready = !queue_full;
  assign accept        = name_ch.valid && name_ch.ready;
  assign b             = name_ch.name_byte;
  assign sent_count    = written_count - WCW'(dash_pending);

  // Decode the byte and decide whether it counts as a letter or separator.
  always_comb begin
    lead_bits_next             = lead_bits;
    lead_valid_next            = lead_valid;
    skipping_continuation_next = skipping_continuation;
    take_en                    = 1'b0;
    take_ch                    = uhs_pkg::CH_NONE;
    if (accept && b != 8'h00 && !length_capped) begin
      if (lead_valid) begin
        lead_valid_next = 1'b0;
        lead_bits_next  = '0;
        take_en         = 1'b1;
        take_ch         = (lead_bits == 5'b00011) ?
                          uhs_pkg::fold_latin({lead_bits[1:0], b[5:0]}) :
                          uhs_pkg::CH_NONE;
      end else if (skipping_continuation && b[7:6] == uhs_pkg::CONT_PREFIX) begin
        skipping_continuation_next = 1'b1;
      end else begin
        skipping_continuation_next = 1'b0;
        if (!b[7]) begin
          take_en = 1'b1;
          take_ch = uhs_pkg::fold_ascii(b);
        end else if (b[7:5] == uhs_pkg::LEAD2_PREFIX) begin
          lead_bits_next  = b[4:0];
          lead_valid_next = 1'b1;
        end else begin
          skipping_continuation_next = 1'b1;
          take_en                    = 1'b1;
        end
      end
    end
  end

  // Count letters and separators, form commands, and handle the end of a name.
  always_comb begin
    written_count_next      = written_count;
    last_was_separator_next = last_was_separator;
    dash_pending_next       = dash_pending;
    length_capped_next      = length_capped;
    push                    = 1'b0;
    push_cmd.kind           = uhs_pkg::CMD_CHAR;
    push_cmd.ch             = take_ch;
    if (accept && b == 8'h00) begin
      push                    = 1'b1;
      push_cmd.kind           = (sent_count == '0) ? uhs_pkg::CMD_END_FALLBACK :
                                                     uhs_pkg::CMD_END;
      written_count_next      = '0;
      last_was_separator_next = 1'b1;
      dash_pending_next       = 1'b0;
      length_capped_next      = 1'b0;
    end else if (take_en) begin
      if (take_ch == uhs_pkg::CH_NONE) begin
        if (!last_was_separator) begin
          dash_pending_next       = 1'b1;
          last_was_separator_next = 1'b1;
          written_count_next      = written_count + 1'b1;
        end
      end else begin
        push                    = 1'b1;
        push_cmd.kind           = dash_pending ? uhs_pkg::CMD_DASH_CHAR : uhs_pkg::CMD_CHAR;
        dash_pending_next       = 1'b0;
        last_was_separator_next = 1'b0;
        written_count_next      = written_count + 1'b1;
      end
      if (written_count_next >= MAX_W) begin
        length_capped_next = 1'b1;
      end
    end
  end

  // State registers; a zero byte returns everything to its reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      written_count         <= '0;
      last_was_separator    <= 1'b1;
      dash_pending          <= 1'b0;
      lead_bits             <= '0;
      lead_valid            <= 1'b0;
      skipping_continuation <= 1'b0;
      length_capped         <= 1'b0;
    end else if (accept && b == 8'h00) begin
      written_count         <= written_count_next;
      last_was_separator    <= last_was_separator_next;
      dash_pending          <= dash_pending_next;
      lead_bits             <= '0;
      lead_valid            <= 1'b0;
      skipping_continuation <= 1'b0;
      length_capped         <= length_capped_next;
    end else begin
      written_count         <= written_count_next;
      last_was_separator    <= last_was_separator_next;
      dash_pending          <= dash_pending_next;
      lead_bits             <= lead_bits_next;
      lead_valid            <= lead_valid_next;
      skipping_continuation <= skipping_continuation_next;
      length_capped         <= length_capped_next;
    end
  end

endmodule

### hdl/uhs_emitter.sv
// Back end: expands queued commands into slug characters in an output register.
module uhs_emitter #(
  parameter int MAX_LEN = uhs_pkg::MAX_LEN_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  uhs_pkg::cmd_t head,
  output logic          pop,
  uhs_slug_if.source    slug_ch
);

  localparam int FB_LIM = (MAX_LEN < uhs_pkg::FALLBACK_LEN) ? MAX_LEN : uhs_pkg::FALLBACK_LEN;
  localparam logic [uhs_pkg::FB_IDX_W-1:0] FB_LIM_C = uhs_pkg::FB_IDX_W'(FB_LIM);

  logic [uhs_pkg::FB_IDX_W-1:0] idx;
  logic                         out_valid;
  logic [7:0]                   out_char;
  logic                         out_end;
  logic                         load;
  logic                         emit;
  logic                         last_step;
  logic [7:0]                   res_char;
  logic                         res_end;

  assign load = !out_valid || slug_ch.ready;
  assign emit = load && head_valid;
  assign pop  = emit && last_step;

  assign slug_ch.valid       = out_valid;
  assign slug_ch.out_char    = out_char;
  assign slug_ch.end_of_slug = out_end;

  // Pick the character for the current step of the head command.
  always_comb begin
    res_char  = uhs_pkg::CH_NONE;
    res_end   = 1'b0;
    last_step = 1'b1;
    unique case (head.kind)
      uhs_pkg::CMD_CHAR: begin
        res_char = head.ch;
      end
      uhs_pkg::CMD_DASH_CHAR: begin
        res_char  = (idx == '0) ? uhs_pkg::CH_DASH : head.ch;
        last_step = (idx != '0);
      end
      uhs_pkg::CMD_END_FALLBACK: begin
        if (idx == FB_LIM_C) begin
          res_end = 1'b1;
        end else begin
          res_char  = uhs_pkg::fallback_char(idx);
          last_step = 1'b0;
        end
      end
      uhs_pkg::CMD_END: begin
        res_end = 1'b1;
      end
      default: begin
        res_end = 1'b0;
      end
    endcase
  end

  // Step counter within a command and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx <= last_step ? '0 : idx + 1'b1;
      end
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= res_char;
      out_end  <= res_end;
    end
  end

endmodule
